// File: hw/rtl/uer_pkg.sv
package uer_pkg;

    // default tick counter width
    localparam int UER_COUNT_WIDTH = 16;

    // register widths
    localparam int TRIG_W    = 10;
    localparam int TMO_W     = 16;
    localparam int HS_W      = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W    = 20;

    // queue depth is 2**UER_Q_ADDR_W entries
    localparam int UER_Q_ADDR_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_START_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_HIGH_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SPEED_Q16     = 2'd3;

    // register reset values
    localparam logic [TRIG_W-1:0] RST_TRIGGER_TICKS      = 10'd20;
    localparam logic [TMO_W-1:0]  RST_ECHO_START_TIMEOUT = 16'd10000;
    localparam logic [TMO_W-1:0]  RST_ECHO_HIGH_TIMEOUT  = 16'd30000;
    localparam logic [HS_W-1:0]   RST_HALF_SPEED_Q16     = 12'd1114;

    // measurement status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ECHO   = 2'd1;
    localparam logic [1:0] ST_ECHO_LONG = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 20'hFFFFF;

    // per-tick control flags handed from front to back
    typedef struct packed {
        logic       trig;
        logic       busy;
        logic       done;
        logic [1:0] status;
    } uer_flags_t;

endpackage

// File: hw/rtl/uer_front.sv
module uer_front
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = UER_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_en,
    input  logic                   start_req,
    input  logic                   echo,
    input  logic [TRIG_W-1:0]      trigger_ticks,
    input  logic [TMO_W-1:0]       echo_start_timeout,
    input  logic [TMO_W-1:0]       echo_high_timeout,
    output uer_flags_t             flags,
    output logic [COUNT_WIDTH-1:0] duration
);

    localparam int CMP_W = (COUNT_WIDTH > TMO_W) ? COUNT_WIDTH : TMO_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [TRIG_W-1:0]      tlen;
    logic                   at_max;
    logic                   trig_over;
    logic                   wait_over;
    logic                   high_over;

    assign tlen      = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
    assign at_max    = (cnt_reg == COUNT_MAX);
    assign trig_over = (CMP_W'(cnt_reg) >= CMP_W'(tlen));
    assign wait_over = (CMP_W'(cnt_reg) >= CMP_W'(echo_start_timeout)) || at_max;
    assign high_over = (CMP_W'(cnt_reg) >= CMP_W'(echo_high_timeout)) || at_max;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        flags.trig   = 1'b0;
        flags.done   = 1'b0;
        flags.status = ST_OK;
        duration     = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next = PH_TRIG;
                    cnt_next   = COUNT_WIDTH'(1);
                    flags.trig = 1'b1;
                end
                else
                begin
                    cnt_next = '0;
                end
            end
            PH_TRIG:
            begin
                if (trig_over)
                begin
                    phase_next = PH_WAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next   = cnt_reg + COUNT_WIDTH'(1);
                    flags.trig = 1'b1;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    phase_next = PH_MEAS;
                    cnt_next   = COUNT_WIDTH'(1);
                end
                else if (wait_over)
                begin
                    phase_next   = PH_IDLE;
                    cnt_next     = '0;
                    flags.done   = 1'b1;
                    flags.status = ST_NO_ECHO;
                end
                else
                begin
                    cnt_next = cnt_reg + COUNT_WIDTH'(1);
                end
            end
            PH_MEAS:
            begin
                if (!echo)
                begin
                    phase_next = PH_IDLE;
                    cnt_next   = '0;
                    flags.done = 1'b1;
                    duration   = cnt_reg;
                end
                else if (high_over)
                begin
                    phase_next   = PH_IDLE;
                    cnt_next     = '0;
                    flags.done   = 1'b1;
                    flags.status = ST_ECHO_LONG;
                end
                else
                begin
                    cnt_next = cnt_reg + COUNT_WIDTH'(1);
                end
            end
        endcase
        flags.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/uer_fifo.sv
module uer_fifo
    import uer_pkg::*;
#(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = UER_Q_ADDR_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ADDR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (ADDR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (ADDR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (ADDR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ADDR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/uer_back.sv
module uer_back
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = UER_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_not_empty,
    input  uer_flags_t             q_flags,
    input  logic [COUNT_WIDTH-1:0] q_duration,
    output logic                   q_pop,
    input  logic [HS_W-1:0]        half_speed_q16,
    output logic                   out_valid,
    input  logic                   out_ready,
    output uer_flags_t             out_flags,
    output logic [DIST_W-1:0]      out_dist
);

    localparam int PROD_W = COUNT_WIDTH + HS_W;
    localparam int EXT_W  = (PROD_W > DIST_W + 8) ? PROD_W : DIST_W + 8;

    // multiply stage
    logic              a_valid_reg;
    uer_flags_t        a_flags_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic              a_adv;

    // output stage
    logic              b_valid_reg;
    uer_flags_t        b_flags_reg;
    logic [DIST_W-1:0] b_dist_reg;

    logic [EXT_W-1:0]  prod_ext;
    logic [EXT_W-1:0]  scaled;
    logic [DIST_W-1:0] dist_sat;

    assign a_adv = !b_valid_reg || out_ready;
    assign q_pop = q_not_empty && (!a_valid_reg || a_adv);

    // drop 8 fraction bits, clamp to the 20 bit range
    assign prod_ext = EXT_W'(a_prod_reg);
    assign scaled   = prod_ext >> 8;
    assign dist_sat = (scaled > EXT_W'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_flags_reg <= q_flags;
            a_prod_reg  <= PROD_W'(q_duration) * PROD_W'(half_speed_q16);
        end
        if (a_adv && a_valid_reg)
        begin
            b_flags_reg <= a_flags_reg;
            b_dist_reg  <= dist_sat;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_flags = b_flags_reg;
    assign out_dist  = b_dist_reg;

endmodule

// File: hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger. Each input beat is one microsecond tick carrying a
// start request and the sampled echo pin; each tick yields exactly one output
// beat with the trigger pin level, busy and done flags, a status (0 ok,
// 1 echo never rose, 2 echo stayed high too long) and the distance in 1/256 cm
// (echo duration times half_speed_q16, shifted right 8, clamped to 20 bits).
// A start while idle drives trigger for trigger_ticks ticks (zero acts as one),
// then the block waits up to echo_start_timeout low ticks for the echo and
// counts up to echo_high_timeout high ticks. One tick is accepted every clock
// cycle while the queue has room; the phase state machine in the front end
// sets this, as each tick's state update finishes in the cycle it is accepted.
// An input beat travels to the output through the 4-entry queue, the multiply
// stage and the output register. If the output side stalls, the queue and back
// end absorb up to six ticks before s_tready drops. Registers are written
// through cfg_we/cfg_addr/cfg_wdata and should only change while no measurement
// is in progress and no beat is still in flight.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_WIDTH = UER_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // input ticks
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] start_req, [1] echo

    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
                                            // [4:3] status, [24:5] distance_q8

    // register writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int Q_W = $bits(uer_flags_t) + COUNT_WIDTH;

    logic [TRIG_W-1:0] trigger_ticks_reg;
    logic [TMO_W-1:0]  echo_start_timeout_reg;
    logic [TMO_W-1:0]  echo_high_timeout_reg;
    logic [HS_W-1:0]   half_speed_q16_reg;

    logic                   tick_en;
    logic                   q_full;
    logic                   q_not_empty;
    logic                   q_pop;
    uer_flags_t             fr_flags;
    logic [COUNT_WIDTH-1:0] fr_duration;
    logic [Q_W-1:0]         q_wdata;
    logic [Q_W-1:0]         q_rdata;
    uer_flags_t             q_flags;
    logic [COUNT_WIDTH-1:0] q_duration;
    uer_flags_t             out_flags;
    logic [DIST_W-1:0]      out_dist;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg      <= RST_TRIGGER_TICKS;
            echo_start_timeout_reg <= RST_ECHO_START_TIMEOUT;
            echo_high_timeout_reg  <= RST_ECHO_HIGH_TIMEOUT;
            half_speed_q16_reg     <= RST_HALF_SPEED_Q16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TRIGGER_TICKS:      trigger_ticks_reg      <= cfg_wdata[TRIG_W-1:0];
                REG_ECHO_START_TIMEOUT: echo_start_timeout_reg <= cfg_wdata[TMO_W-1:0];
                REG_ECHO_HIGH_TIMEOUT:  echo_high_timeout_reg  <= cfg_wdata[TMO_W-1:0];
                REG_HALF_SPEED_Q16:     half_speed_q16_reg     <= cfg_wdata[HS_W-1:0];
            endcase
        end
    end

    // a tick is taken whenever the queue has room
    assign s_tready = !q_full;
    assign tick_en  = s_tvalid && s_tready;

    uer_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .tick_en           (tick_en),
        .start_req         (s_tdata[0]),
        .echo              (s_tdata[1]),
        .trigger_ticks     (trigger_ticks_reg),
        .echo_start_timeout(echo_start_timeout_reg),
        .echo_high_timeout (echo_high_timeout_reg),
        .flags             (fr_flags),
        .duration          (fr_duration)
    );

    // flags and raw duration travel together; distance is formed in the back end
    assign q_wdata    = {fr_flags, fr_duration};
    assign q_flags    = q_rdata[Q_W-1:COUNT_WIDTH];
    assign q_duration = q_rdata[COUNT_WIDTH-1:0];

    uer_fifo #(
        .WIDTH (Q_W),
        .ADDR_W(UER_Q_ADDR_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (tick_en),
        .push_data(q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .not_empty(q_not_empty)
    );

    uer_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_flags       (q_flags),
        .q_duration    (q_duration),
        .q_pop         (q_pop),
        .half_speed_q16(half_speed_q16_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_flags     (out_flags),
        .out_dist      (out_dist)
    );

    // result beat packing, first field lowest
    assign m_tdata = {7'd0, out_dist, out_flags.status, out_flags.done,
                      out_flags.busy, out_flags.trig};

endmodule

// File: hw/rtl/uer_checker.sv
module uer_checker
    import uer_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a finished measurement is never still busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
        else $error("done and busy in the same beat");

    // status only on the finishing tick
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[4:3] == ST_OK)
        else $error("status set without done");

    // distance only from a good measurement
    a_dist_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[24:5] != '0) |-> m_tdata[2] && (m_tdata[4:3] == ST_OK))
        else $error("distance reported without a good measurement");

    // trigger is driven only while a measurement runs
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("trigger high while not busy");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

// File: sim/echo_ranger_checker.sv
`timescale 1ns / 100ps

module echo_ranger_checker
    import uer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] start_req, [1] echo

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // [0] trigger, [1] busy_res, [2] done_res,
                                            // [4:3] status, [24:5] distance_q8

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,

    output int                   errors,
    output int                   pending,
    output logic                 meas_busy,
    output int                   n_results,
    output int                   n_ranges,
    output int                   n_no_echo,
    output int                   n_long_echo
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } ranger_phase_e;

    // same bit order as m_tdata
    typedef struct packed {
        logic [DIST_W-1:0] range_q8;
        logic [1:0]        status;
        logic              done;
        logic              busy;
        logic              trig;
    } tick_res_t;

    localparam int unsigned CNT_MAX = (1 << UER_COUNT_WIDTH) - 1;

    logic [TRIG_W-1:0] trig_len;
    logic [TMO_W-1:0]  rise_tmo;
    logic [TMO_W-1:0]  high_tmo;
    logic [HS_W-1:0]   half_speed;

    ranger_phase_e     phase;
    int unsigned       tick_cnt;
    tick_res_t         ticks_due[$];

    function automatic logic [DIST_W-1:0] to_dist(int unsigned dur);
        logic [63:0] prod;
        prod = (64'(dur) * 64'(half_speed)) >> 8;
        if (prod > 64'(DIST_MAX))
            return DIST_MAX;
        return prod[DIST_W-1:0];
    endfunction

    // one tick of the ranger: moves the phase and returns that tick's beat
    function automatic tick_res_t advance(logic start, logic echo);
        tick_res_t   r;
        int unsigned tlen;
        r = '0;
        tlen = (trig_len == 0) ? 1 : trig_len;
        case (phase)
            PH_TRIG:
                if (tick_cnt >= tlen)
                begin
                    phase = PH_WAIT;
                    tick_cnt = 0;
                end
                else
                begin
                    tick_cnt++;
                    r.trig = 1'b1;
                end
            PH_WAIT:
                if (echo)
                begin
                    phase = PH_MEAS;
                    tick_cnt = 1;
                end
                else if (tick_cnt >= rise_tmo || tick_cnt >= CNT_MAX)
                begin
                    phase = PH_IDLE;
                    tick_cnt = 0;
                    r.done = 1'b1;
                    r.status = ST_NO_ECHO;
                end
                else
                    tick_cnt++;
            PH_MEAS:
                if (!echo)
                begin
                    r.range_q8 = to_dist(tick_cnt);
                    phase = PH_IDLE;
                    tick_cnt = 0;
                    r.done = 1'b1;
                    r.status = ST_OK;
                end
                else if (tick_cnt >= high_tmo || tick_cnt >= CNT_MAX)
                begin
                    phase = PH_IDLE;
                    tick_cnt = 0;
                    r.done = 1'b1;
                    r.status = ST_ECHO_LONG;
                end
                else
                    tick_cnt++;
            default:
                if (start)
                begin
                    phase = PH_TRIG;
                    tick_cnt = 1;
                    r.trig = 1'b1;
                end
                else
                begin
                    phase = PH_IDLE;
                    tick_cnt = 0;
                end
        endcase
        r.busy = (phase != PH_IDLE);
        return r;
    endfunction

    function automatic void miss(string field, int unsigned want, int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        tick_res_t got;
        tick_res_t want;
        if (!rst_n)
        begin
            trig_len = RST_TRIGGER_TICKS;
            rise_tmo = RST_ECHO_START_TIMEOUT;
            high_tmo = RST_ECHO_HIGH_TIMEOUT;
            half_speed = RST_HALF_SPEED_Q16;
            phase = PH_IDLE;
            tick_cnt = 0;
            ticks_due.delete();
            errors = 0;
            n_results = 0;
            n_ranges = 0;
            n_no_echo = 0;
            n_long_echo = 0;
            pending <= 0;
            meas_busy <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(tick_res_t)-1:0];
                if (ticks_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no tick waiting, expected none, got %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = ticks_due.pop_front();
                    n_results++;
                    if (got.trig != want.trig)
                        miss("trigger", want.trig, got.trig);
                    if (got.busy != want.busy)
                        miss("busy_res", want.busy, got.busy);
                    if (got.done != want.done)
                        miss("done_res", want.done, got.done);
                    if (got.status != want.status)
                        miss("status", want.status, got.status);
                    if (got.range_q8 != want.range_q8)
                        miss("distance_q8", want.range_q8, got.range_q8);
                    if (want.done)
                        case (want.status)
                            ST_OK:        n_ranges++;
                            ST_NO_ECHO:   n_no_echo++;
                            ST_ECHO_LONG: n_long_echo++;
                            default:      ;
                        endcase
                end
            end

            if (cfg_we)
                case (cfg_addr)
                    REG_TRIGGER_TICKS:      trig_len = cfg_wdata[TRIG_W-1:0];
                    REG_ECHO_START_TIMEOUT: rise_tmo = cfg_wdata[TMO_W-1:0];
                    REG_ECHO_HIGH_TIMEOUT:  high_tmo = cfg_wdata[TMO_W-1:0];
                    REG_HALF_SPEED_Q16:     half_speed = cfg_wdata[HS_W-1:0];
                    default:                ;
                endcase

            if (s_tvalid && s_tready)
                ticks_due.push_back(advance(s_tdata[0], s_tdata[1]));

            pending <= ticks_due.size();
            meas_busy <= (phase != PH_IDLE);
        end
    end

endmodule

// File: sim/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int HOLD_CYCLES  = 300;         // long output stall, fills the queue
    localparam int RANDOM_TICKS = 900;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [0] start_req, [1] echo
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // [0] trigger, [1] busy_res, [2] done_res,
                                     // [4:3] status, [24:5] distance_q8
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;

    // checker outputs
    int   errors;
    int   pending;
    logic meas_busy;
    int   n_results;
    int   n_ranges;
    int   n_no_echo;
    int   n_long_echo;

    // stimulus controls
    bit          calm;            // no idling on either side
    bit          hold_req;        // ask the sink for one long stall
    bit          stray_starts;    // sprinkle start requests into busy ticks
    int          gap_odds = 12;   // percent chance of a sender gap before a beat
    int unsigned trig_len = RST_TRIGGER_TICKS;   // pulse length as the block sees it
    int          sent;            // ticks sent in the current part
    int          settings;        // register settings used
    int          cycles;

    ultrasonic_echo_ranger u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    echo_ranger_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .pending     (pending),
        .meas_busy   (meas_busy),
        .n_results   (n_results),
        .n_ranges    (n_ranges),
        .n_no_echo   (n_no_echo),
        .n_long_echo (n_long_echo)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result beats outstanding", cycles, pending);
            $display("ultrasonic_echo_ranger_tb: FAIL");
            $finish;
        end
    end

    // result sink: random stall bursts, quiet stretches, one long hold-off on request
    initial
    begin : sink
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    n++;
                end
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                // stretch with no stalls
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // start request while a measurement is running, which the block ignores
    function automatic logic busy_start();
        return stray_starts && ($urandom_range(0, 7) == 0);
    endfunction

    // one tick beat; called and returns on a rising edge, valid left high
    task automatic send_tick(input logic start, input logic echo);
        if (!calm && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, echo, start};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    // finish any running measurement with alternating echo, then wait for every
    // expected beat so the registers can be rewritten safely
    task automatic settle();
        logic ec;
        ec = 1'b0;
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (meas_busy)
        begin
            @(posedge clk);
            ec = !ec;
            send_tick(1'b0, ec);
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic program_regs(input int unsigned tt, input int unsigned rise_lim,
                                input int unsigned high_lim, input int unsigned hs);
        cfg_we <= 1'b1;
        cfg_addr <= REG_TRIGGER_TICKS;
        cfg_wdata <= CFG_W'(tt);
        @(posedge clk);
        cfg_addr <= REG_ECHO_START_TIMEOUT;
        cfg_wdata <= CFG_W'(rise_lim);
        @(posedge clk);
        cfg_addr <= REG_ECHO_HIGH_TIMEOUT;
        cfg_wdata <= CFG_W'(high_lim);
        @(posedge clk);
        cfg_addr <= REG_HALF_SPEED_Q16;
        cfg_wdata <= CFG_W'(hs);
        @(posedge clk);
        cfg_we <= 1'b0;
        trig_len = (tt[TRIG_W-1:0] == 0) ? 1 : tt[TRIG_W-1:0];
        settings++;
    endtask

    // well-formed measurement: start, trigger pulse, low wait, echo high, echo fall.
    // if a timeout hits first, the remaining ticks land in idle, where only a
    // stray start does anything
    task automatic measure(input int unsigned rise_wait, input int unsigned high_len,
                           input int unsigned idle_after);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (trig_len)
            send_tick(busy_start(), 1'($urandom_range(0, 1)));   // echo ignored here
        repeat (rise_wait)
            send_tick(busy_start(), 1'b0);
        repeat (high_len)
            send_tick(busy_start(), 1'b1);
        send_tick(busy_start(), 1'b0);
        repeat (idle_after)
            send_tick(1'b0, 1'($urandom_range(0, 1)));
        sent += 2 + trig_len + rise_wait + high_len + idle_after;
    endtask

    // unstructured ticks: random starts and echo glitches
    task automatic chatter(input int unsigned n);
        repeat (n)
            send_tick(1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
        sent += n;
    endtask

    initial
    begin : stimulus
        int unsigned tt;
        int unsigned rise_lim;
        int unsigned high_lim;
        int unsigned hs;

        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= REG_TRIGGER_TICKS;
        cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset register values first, echo while idle is ignored
        send_tick(1'b0, 1'b1);
        measure(2, 4, 1);

        // zero trigger length acts as one tick, zero timeouts, full-scale speed
        settle();
        program_regs(0, 0, 0, 4095);
        measure(0, 1, 1);      // shortest echo
        measure(1, 0, 1);      // first low wait tick fails
        measure(0, 2, 1);      // first extra high tick fails

        // timeouts just met and just exceeded, zero speed gives zero distance
        settle();
        program_regs(1, 3, 4, 0);
        measure(3, 4, 0);
        measure(4, 1, 0);
        measure(0, 5, 0);

        // random settings, mostly well-formed measurements around the timeouts
        stray_starts = 1'b1;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            settle();
            case ($urandom_range(0, 5))
                0:       tt = 0;
                1:       tt = 1;
                default: tt = $urandom_range(2, 12);
            endcase
            rise_lim = $urandom_range(0, 30);
            high_lim = $urandom_range(0, 40);
            case ($urandom_range(0, 3))
                0:       hs = 0;
                1:       hs = 4095;
                default: hs = $urandom_range(0, 4095);
            endcase
            program_regs(tt, rise_lim, high_lim, hs);
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (sent == 0)
                hold_req = 1'b1;   // sink stalls while ticks keep coming
            repeat (6)
            begin
                if ($urandom_range(0, 5) == 0)
                    chatter($urandom_range(5, 30));
                else
                    measure($urandom_range(0, rise_lim + 2), $urandom_range(1, high_lim + 2),
                            $urandom_range(0, 3));
            end
        end

        // largest timeouts and speed with a long echo, run without idling
        settle();
        calm = 1'b1;
        stray_starts = 1'b0;
        program_regs(64, 65535, 65535, 4095);
        measure(7, 300, 2);

        // closing part, still no idling
        settle();
        program_regs($urandom_range(1, 6), $urandom_range(5, 20), $urandom_range(5, 20),
                     $urandom_range(0, 4095));
        stray_starts = 1'b1;
        repeat (8)
            measure($urandom_range(0, 22), $urandom_range(1, 22), $urandom_range(0, 2));

        settle();
        repeat (8) @(posedge clk);

        $display("checked %0d result beats over %0d register settings", n_results, settings);
        $display("measurements: %0d ranged, %0d no-echo timeouts, %0d long-echo timeouts",
                 n_ranges, n_no_echo, n_long_echo);
        if (errors == 0)
            $display("ultrasonic_echo_ranger_tb: PASS");
        else
            $display("ultrasonic_echo_ranger_tb: FAIL");
        $finish;
    end

endmodule
